/* hw/rtl/button_random_number_lcd_writer_defines.svh */
// Assertion macros for the button random number LCD writer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BUTTON_RANDOM_NUMBER_LCD_WRITER_DEFINES_SVH
`define BUTTON_RANDOM_NUMBER_LCD_WRITER_DEFINES_SVH

// Condition that must hold on every clock edge out of reset.
`define RNLW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Cause in one cycle, effect in the next.
`define RNLW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hw/rtl/rnlw_pkg.sv */
// Shared constants and types for the button random number LCD writer.
// No dependencies.
`timescale 1ns / 1ps

package rnlw_pkg;

  localparam logic [31:0] LCG_MUL    = 32'd1103515245;
  localparam logic [31:0] LCG_ADD    = 32'd12345;
  localparam logic [31:0] SEED_RESET = 32'd12345;

  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CMD_HOME   = 8'h80;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  localparam int NUM_DIGITS = 10;
  localparam int BIN_W      = 31;
  localparam int CNT_W      = $clog2(BIN_W);
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t [NUM_DIGITS-1:0] bcd_vec_t;

  typedef struct packed {
    logic cfg_load;
    logic advance;
  } lcg_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dbl_status_t;

endpackage

/* hw/rtl/rnlw_lcg.sv */
// Generator state register with one multiply-add step per advance.
// Depends on rnlw_pkg.
`timescale 1ns / 1ps

module rnlw_lcg import rnlw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lcg_ctrl_t   ctrl_i,
  input  logic [31:0] seed_i,
  output logic [31:0] state_o
);

  logic [31:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    if (ctrl_i.cfg_load) begin
      state_d = seed_i;
    end else if (ctrl_i.advance) begin
      state_d = state_q * LCG_MUL + LCG_ADD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEED_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

/* hw/rtl/rnlw_dabble.sv */
// Iterative binary to BCD converter, one input bit per cycle (shift/add-3).
// Depends on rnlw_pkg.
`timescale 1ns / 1ps

module rnlw_dabble import rnlw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [BIN_W-1:0]  bin_i,
  output dbl_status_t       status_o,
  output bcd_vec_t          bcd_o
);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [BIN_W-1:0] bin_q;
  bcd_vec_t         bcd_q, bcd_d, corr;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      corr[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
    bcd_d[0] = {corr[0][2:0], bin_q[BIN_W-1]};
    for (int i = 1; i < NUM_DIGITS; i++) begin
      bcd_d[i] = {corr[i][2:0], corr[i-1][3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(BIN_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      bin_q <= bin_i;
      bcd_q <= '0;
    end else if (busy_q) begin
      bin_q <= bin_q << 1;
      bcd_q <= bcd_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign bcd_o         = bcd_q;

endmodule

/* hw/rtl/button_random_number_lcd_writer.sv */
// Button random number LCD writer: each accepted button sample may print
// a fresh pseudo-random number as an LCD byte stream (clear, home, digits).
// A printing transaction steps the generator, loads the shift/add-3 converter,
// runs the 31-bit binary-to-BCD conversion, then emits the two command bytes,
// skips leading zeros and emits the digits; each byte waits while out_stall_i
// holds the output register. A sample that prints nothing leaves the block
// idle. in_stall_o stays high until the last digit is in the output register.
// Depends on rnlw_pkg, rnlw_lcg, rnlw_dabble and the defines header.
`timescale 1ns / 1ps
`include "button_random_number_lcd_writer_defines.svh"

module button_random_number_lcd_writer import rnlw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_seed_start_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        button_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  lcd_value_o,
  output logic        register_select_o,
  output logic        last_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADV   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_CLR   = 3'd4;
  localparam logic [2:0] ST_HOME  = 3'd5;
  localparam logic [2:0] ST_SKIP  = 3'd6;
  localparam logic [2:0] ST_DIG   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic             prev_q, prev_d;
  logic             startup_q, startup_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q;
  logic [7:0]       out_value_q;
  logic             out_rs_q, out_last_q;

  logic        in_acc, out_free, print;
  logic        emit, emit_rs, emit_last;
  logic [7:0]  emit_value;
  logic        dbl_start;
  lcg_ctrl_t   lcg_ctrl;
  dbl_status_t dbl_status;
  logic [31:0] gen;
  bcd_vec_t    bcd;
  bcd_digit_t  cur_digit;
  logic        cmd_ok, digit_ok, seq_end;

  rnlw_lcg u_lcg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lcg_ctrl),
    .seed_i  (cfg_seed_start_i),
    .state_o (gen)
  );

  rnlw_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (dbl_start),
    .bin_i    (gen[31:1]),
    .status_o (dbl_status),
    .bcd_o    (bcd)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign print       = startup_q || (prev_q && !button_level_i);
  assign cur_digit   = bcd[idx_q];

  assign lcg_ctrl.cfg_load = cfg_valid_i && cfg_ready_o;
  assign lcg_ctrl.advance  = (state_q == ST_ADV);
  assign dbl_start         = (state_q == ST_START);

  always_comb begin
    state_d    = state_q;
    prev_d     = prev_q;
    startup_d  = startup_q;
    idx_d      = idx_q;
    emit       = 1'b0;
    emit_value = CMD_CLEAR;
    emit_rs    = 1'b0;
    emit_last  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          prev_d    = button_level_i;
          startup_d = 1'b0;
          if (print) begin
            state_d = ST_ADV;
          end
        end
      end
      ST_ADV:   state_d = ST_START;
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (dbl_status.done) begin
          state_d = ST_CLR;
          idx_d   = IDX_W'(NUM_DIGITS - 1);
        end
      end
      ST_CLR: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_HOME;
        end
      end
      ST_HOME: begin
        emit_value = CMD_HOME;
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (cur_digit == '0 && idx_q != '0) begin
          idx_d = idx_q - 1'b1;
        end else begin
          state_d = ST_DIG;
        end
      end
      ST_DIG: begin
        emit_value = ASCII_ZERO | {4'h0, cur_digit};
        emit_rs    = 1'b1;
        emit_last  = (idx_q == '0);
        if (out_free) begin
          emit = 1'b1;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= 1'b1;
      startup_q   <= 1'b1;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      prev_q    <= prev_d;
      startup_q <= startup_d;
      idx_q     <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q <= emit_value;
      out_rs_q    <= emit_rs;
      out_last_q  <= emit_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign lcd_value_o       = out_value_q;
  assign register_select_o = out_rs_q;
  assign last_o            = out_last_q;

  assign cmd_ok   = !last_o && (lcd_value_o == CMD_CLEAR || lcd_value_o == CMD_HOME);
  assign digit_ok = (lcd_value_o[7:4] == 4'h3) && (lcd_value_o[3:0] <= 4'd9);
  assign seq_end  = (state_q == ST_IDLE) && out_valid_q && out_last_q;

  `RNLW_ASSERT(a_last_is_data, !(out_valid_o && last_o) || register_select_o, "last on command")
  `RNLW_ASSERT(a_cmd_code, !(out_valid_o && !register_select_o) || cmd_ok, "bad command byte")
  `RNLW_ASSERT(a_digit_ascii, !(out_valid_o && register_select_o) || digit_ok, "bad digit byte")
  `RNLW_ASSERT_NEXT(a_last_ends, emit && emit_last, seq_end, "sequence did not end")
  `RNLW_ASSERT(a_dbl_idle, !in_acc || !dbl_status.busy, "converter busy on accept")

endmodule
